// ----- hdl/fcsma_pkg.sv -----
// Shared constants and control struct for the five-channel moving average core.
`default_nettype none

package fcsma_pkg;

   localparam int WINDOW_MAX_DEF  = 256;  // deepest window in records
   localparam int VALUE_WIDTH_DEF = 32;   // bits per price / volume value
   localparam int CHANNELS        = 5;    // open, close, high, low, volume

   // sequencer -> lane controls
   typedef struct packed {
      logic clear;     // empty the running sum
      logic load;      // latch new and oldest value into the serial shifters
      logic use_old;   // window was full: oldest value is subtracted
      logic upd_step;  // one bit of sum + new - old, LSB first
      logic div_load;  // seed divider from the updated sum
      logic div_step;  // one quotient bit, MSB first
   } lane_ctrl_type;

endpackage

`default_nettype wire

// ----- hdl/fcsma_lane.sv -----
// One channel: running sum with bit-serial update and bit-serial divide by count.
`default_nettype none

module fcsma_lane
   import fcsma_pkg::*;
#(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire lane_ctrl_type                      ctrl,
   input  wire logic [VALUE_WIDTH-1:0]             new_value,
   input  wire logic [VALUE_WIDTH-1:0]             old_value,
   input  wire logic [$clog2(WINDOW_MAX+1)-1:0]    count,
   output logic      [VALUE_WIDTH-1:0]             quotient
);

   localparam int PTR_W = $clog2(WINDOW_MAX);
   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W = VALUE_WIDTH + PTR_W;

   logic [SUM_W-1:0]       sum_ff;
   logic [VALUE_WIDTH-1:0] new_sh_ff;
   logic [VALUE_WIDTH-1:0] old_sh_ff;
   logic [1:0]             carry_ff;   // two's complement, -1..1
   logic [CNT_W-1:0]       rem_ff;
   logic [VALUE_WIDTH-1:0] quo_ff;

   logic                   sub_bit;
   logic [2:0]             digit_in;   // two's complement, -2..3
   logic [1:0]             carry_in;
   logic [CNT_W:0]         trial;
   logic [CNT_W:0]         diff;
   logic                   fits;
   logic [CNT_W-1:0]       rem_in;

   // serial add/subtract: sum bit + new bit - old bit + carry
   always_comb begin
      sub_bit  = ctrl.use_old & old_sh_ff[0];
      digit_in = 3'(sum_ff[0]) + 3'(new_sh_ff[0]) - 3'(sub_bit) + {carry_ff[1], carry_ff};
      carry_in = digit_in[2:1];
   end

   // restoring divide step; remainder always stays below count
   always_comb begin
      trial  = {rem_ff, quo_ff[VALUE_WIDTH-1]};
      diff   = trial - {1'b0, count};
      fits   = (trial >= {1'b0, count});
      rem_in = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (ctrl.clear) begin
         sum_ff <= '0;
      end else if (ctrl.upd_step) begin
         sum_ff <= {digit_in[0], sum_ff[SUM_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         new_sh_ff <= new_value;
         old_sh_ff <= old_value;
         carry_ff  <= '0;
      end else if (ctrl.upd_step) begin
         new_sh_ff <= new_sh_ff >> 1;
         old_sh_ff <= old_sh_ff >> 1;
         carry_ff  <= carry_in;
      end
   end

   // quotient fits VALUE_WIDTH bits, so the top PTR_W sum bits seed the remainder
   always_ff @(posedge clock) begin
      if (ctrl.div_load) begin
         rem_ff <= CNT_W'(sum_ff[SUM_W-1:VALUE_WIDTH]);
         quo_ff <= sum_ff[VALUE_WIDTH-1:0];
      end else if (ctrl.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[VALUE_WIDTH-2:0], fits};
      end
   end

   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- hdl/five_channel_simple_moving_average_core.sv -----
// Five-channel simple moving average over a sliding window of price records.
//
// Input item (req_ stream): open, close, high, low price and volume. Result
// item (rsp_ stream): the five window means, truncated, plus the record count.
// window_len is read over the csr_ APB port at byte address 0; any write, to any
// address, also of the same value, sets it and empties the window. Only data bits
// CNT_W-1:0 are used; 0 is taken as 1, values above WINDOW_MAX as WINDOW_MAX.
// Write it only while no item is in flight; req_tready is held low in the
// cycle of a write. An accepted item is loaded into the serial shifters of
// all five lanes, which then run side by side through the bit-serial sum
// update over SUM_W = VALUE_WIDTH + log2(WINDOW_MAX) bits, the divider seed
// and the bit-serial divide over VALUE_WIDTH quotient bits. The result is then
// loaded into the output register, raising rsp_tvalid, before a new item is taken.
// The result sits in its own output register, so the next item is taken while
// it waits; if the receiver still stalls when the following result is ready,
// the core holds in its final state until the register frees up.
// Reset: window_len = WINDOW_MAX, window empty, sums zero. The ring memory is
// not cleared; a row's value is used only after it was written.
`default_nettype none

module five_channel_simple_moving_average_core
   import fcsma_pkg::*;
#(
   parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,

   // {trade_volume, low_price, high_price, close_price, open_price}, open lowest
   input  wire logic [((CHANNELS*VALUE_WIDTH+7)/8)*8-1:0]                       req_tdata,
   input  wire logic                                                            req_tvalid,
   output logic                                                                 req_tready,

   // open_average, close_average, high_average, low_average, volume_average,
   // window_count, from the lowest bit up, zero padded to whole bytes
   output logic [((CHANNELS*VALUE_WIDTH+$clog2(WINDOW_MAX+1)+7)/8)*8-1:0]       rsp_tdata,
   output logic                                                                 rsp_tvalid,
   input  wire logic                                                            rsp_tready,

   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [1:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   localparam int PTR_W  = $clog2(WINDOW_MAX);
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W  = VALUE_WIDTH + PTR_W;
   localparam int STEP_W = $clog2(SUM_W);
   localparam int ROW_W  = CHANNELS * VALUE_WIDTH;
   localparam int OUT_W  = ((ROW_W + CNT_W + 7) / 8) * 8;

   localparam logic [1:0] REG_WINDOW_LEN = 2'd0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_UPDATE,
      ST_DIV_LOAD,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   window_len_ff;
   logic [CNT_W-1:0]   held_ff;
   logic [PTR_W-1:0]   oldest_ff;
   logic               full_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [ROW_W-1:0]   new_ff;
   logic [ROW_W-1:0]   old_ff;
   logic [OUT_W-1:0]   rsp_tdata_ff;
   logic               rsp_tvalid_ff;

   // one row holds all five channels of a record
   logic [ROW_W-1:0]   ring_mem [WINDOW_MAX];

   logic               accept;
   logic               cfg_write;
   logic [CNT_W-1:0]   len_in;
   logic               full;
   logic [CNT_W:0]     pos_sum;
   logic [CNT_W:0]     pos_wrap;
   logic [PTR_W-1:0]   slot_in;
   logic [CNT_W-1:0]   next_ptr;
   logic [PTR_W-1:0]   oldest_in;
   logic [OUT_W-1:0]   out_word_in;
   lane_ctrl_type      lane_ctrl;
   logic [VALUE_WIDTH-1:0] quo [CHANNELS];

   assign accept     = req_tvalid & req_tready;
   assign req_tready = (state_ff == ST_IDLE) & ~cfg_write;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == REG_WINDOW_LEN) ? 32'(window_len_ff) : '0;

   // clamp window length into 1..WINDOW_MAX
   always_comb begin
      len_in = csr_pwdata[CNT_W-1:0];
      if (len_in == '0) begin
         len_in = CNT_W'(1);
      end else if (len_in > CNT_W'(WINDOW_MAX)) begin
         len_in = CNT_W'(WINDOW_MAX);
      end
   end

   // slot for the incoming record: oldest slot when full, else first free one
   always_comb begin
      full     = (held_ff == window_len_ff);
      pos_sum  = (CNT_W+1)'(oldest_ff) + (CNT_W+1)'(held_ff);
      pos_wrap = pos_sum - (CNT_W+1)'(window_len_ff);
      next_ptr = CNT_W'(oldest_ff) + CNT_W'(1);
      oldest_in = (next_ptr >= window_len_ff) ? '0 : next_ptr[PTR_W-1:0];
      if (full) begin
         slot_in = oldest_ff;
      end else if (pos_sum >= (CNT_W+1)'(window_len_ff)) begin
         slot_in = pos_wrap[PTR_W-1:0];
      end else begin
         slot_in = pos_sum[PTR_W-1:0];
      end
   end

   // read of the oldest row comes before the write of the new one
   always_ff @(posedge clock) begin
      if (accept) begin
         old_ff            <= ring_mem[oldest_ff];
         ring_mem[slot_in] <= req_tdata[ROW_W-1:0];
      end
   end

   always_comb begin
      lane_ctrl.clear    = cfg_write;
      lane_ctrl.load     = (state_ff == ST_LOAD);
      lane_ctrl.use_old  = full_ff;
      lane_ctrl.upd_step = (state_ff == ST_UPDATE);
      lane_ctrl.div_load = (state_ff == ST_DIV_LOAD);
      lane_ctrl.div_step = (state_ff == ST_DIVIDE);
   end

   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      fcsma_lane #(
         .WINDOW_MAX  (WINDOW_MAX),
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (lane_ctrl),
         .new_value (new_ff[c*VALUE_WIDTH +: VALUE_WIDTH]),
         .old_value (old_ff[c*VALUE_WIDTH +: VALUE_WIDTH]),
         .count     (held_ff),
         .quotient  (quo[c])
      );
   end

   always_comb begin
      out_word_in = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         out_word_in[c*VALUE_WIDTH +: VALUE_WIDTH] = quo[c];
      end
      out_word_in[ROW_W +: CNT_W] = held_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_len_ff <= CNT_W'(WINDOW_MAX);
         held_ff       <= '0;
         oldest_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // in ST_DONE the output register is reloaded below instead
         if (rsp_tvalid_ff && rsp_tready && state_ff != ST_DONE) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (cfg_write) begin
            window_len_ff <= len_in;
            held_ff       <= '0;
            oldest_ff     <= '0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  full_ff <= full;
                  new_ff  <= req_tdata[ROW_W-1:0];
                  if (full) begin
                     oldest_ff <= oldest_in;
                  end else begin
                     held_ff <= held_ff + CNT_W'(1);
                  end
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               step_ff  <= STEP_W'(SUM_W - 1);
               state_ff <= ST_UPDATE;
            end
            ST_UPDATE: begin
               if (step_ff == '0) begin
                  state_ff <= ST_DIV_LOAD;
               end else begin
                  step_ff <= step_ff - STEP_W'(1);
               end
            end
            ST_DIV_LOAD: begin
               step_ff  <= STEP_W'(VALUE_WIDTH - 1);
               state_ff <= ST_DIVIDE;
            end
            ST_DIVIDE: begin
               if (step_ff == '0) begin
                  state_ff <= ST_DONE;
               end else begin
                  step_ff <= step_ff - STEP_W'(1);
               end
            end
            ST_DONE: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tdata_ff  <= out_word_in;
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

`default_nettype wire
